/* rtl/core/sfr_pkg.sv */
// sfr_pkg: shared types, constants and helper functions for the symbol frequency rank core
// no dependencies; imported by sfr_ctrl, sfr_dpath, symbol_frequency_rank_core and tb
`default_nettype none

package sfr_pkg;

   // counter and table geometry
   localparam int COUNT_WIDTH = 16;
   localparam int NUM_CLASSES = 30;
   localparam int NUM_LETTERS = 26;
   localparam int IDX_W       = $clog2(NUM_CLASSES);
   localparam int OUT_CNT_W   = 16;
   localparam int EXT_W       = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

   localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(NUM_CLASSES - 1);
   localparam logic [IDX_W-1:0] LAST_SORT_IDX = IDX_W'(NUM_CLASSES - 2);

   // ascii codes
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_Z   = 8'h7a;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_Z   = 8'h5a;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_PERIOD = 8'h2e;
   localparam logic [7:0] CHAR_EXCL   = 8'h21;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // class slots of the punctuation symbols
   localparam logic [IDX_W-1:0] CLS_COMMA  = IDX_W'(NUM_LETTERS);
   localparam logic [IDX_W-1:0] CLS_PERIOD = IDX_W'(NUM_LETTERS + 1);
   localparam logic [IDX_W-1:0] CLS_EXCL   = IDX_W'(NUM_LETTERS + 2);
   localparam logic [IDX_W-1:0] CLS_SPACE  = IDX_W'(NUM_LETTERS + 3);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]           symbol_code;
      logic [OUT_CNT_W-1:0] symbol_count;
      logic                 rank_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]             sym;
      logic [COUNT_WIDTH-1:0] cnt;
   } entry_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } cls_type;

   // what the registered read data is used for in the following cycle
   typedef enum logic [1:0] {
      TAG_NONE  = 2'd0,
      TAG_FIRST = 2'd1,
      TAG_CMP   = 2'd2
   } tag_type;

   typedef struct packed {
      logic             count_rd;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      tag_type          rd_tag;
      logic             wr_j;
      logic             wr_b;
      logic [IDX_W-1:0] j_addr;
      logic             out_load;
      logic             clear;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

   function automatic cls_type class_of(input logic [7:0] b);
      cls_type    r;
      logic [7:0] off;
      r.hit = 1'b0;
      r.idx = '0;
      off   = '0;
      if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
         off   = b - CHAR_LC_A;
         r.hit = 1'b1;
         r.idx = off[IDX_W-1:0];
      end else if (b >= CHAR_UC_A && b <= CHAR_UC_Z) begin
         off   = b - CHAR_UC_A;
         r.hit = 1'b1;
         r.idx = off[IDX_W-1:0];
      end else if (b == CHAR_COMMA) begin
         r.hit = 1'b1;
         r.idx = CLS_COMMA;
      end else if (b == CHAR_PERIOD) begin
         r.hit = 1'b1;
         r.idx = CLS_PERIOD;
      end else if (b == CHAR_EXCL) begin
         r.hit = 1'b1;
         r.idx = CLS_EXCL;
      end else if (b == CHAR_SPACE) begin
         r.hit = 1'b1;
         r.idx = CLS_SPACE;
      end
      return r;
   endfunction

   // symbol that sits in a slot after reset
   function automatic logic [7:0] reset_symbol(input logic [IDX_W-1:0] idx);
      logic [7:0] s;
      s = CHAR_LC_A + 8'(idx);
      if (idx == CLS_COMMA) begin
         s = CHAR_COMMA;
      end else if (idx == CLS_PERIOD) begin
         s = CHAR_PERIOD;
      end else if (idx == CLS_EXCL) begin
         s = CHAR_EXCL;
      end else if (idx == CLS_SPACE) begin
         s = CHAR_SPACE;
      end
      return s;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] c);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(c);
      if (ext > EXT_W'({OUT_CNT_W{1'b1}})) begin
         return '1;
      end
      return ext[OUT_CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/symbol_frequency_rank_core.sv */
// symbol_frequency_rank_core: top level, 30-class symbol histogram ranked by selection sort
// depends on sfr_pkg, sfr_ctrl and sfr_dpath
// counting: one byte per cycle, each count is a read-modify-write on a 30-entry table
// after a last_byte transfer: a drain state, then per position j a load, a scan of the later slots,
//   and writes of slot j and the best slot; the results are then read and loaded one at a time
// input is stalled from the last_byte transfer until the thirtieth result is loaded
// synchronous active-high reset empties the table (all counts zero, symbols a..z then , . ! space)
`default_nettype none

module symbol_frequency_rank_core
   import sfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // byte stream
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   // ranked results
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: counting phase, per-position scan and swap, readout
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_byte),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: table memory with valid bits, saturating counters, best tracker,
   // output register so the last result can wait while new text is taken
   sfr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/sfr_ctrl.sv */
// sfr_ctrl: sequencer for counting, selection sort and result readout
// depends on sfr_pkg for the command and status types
`default_nettype none

module sfr_ctrl
   import sfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_last,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_COUNT     = 9'b000000001,
      ST_DRAIN     = 9'b000000010,
      ST_SORT_LOAD = 9'b000000100,
      ST_SORT_SCAN = 9'b000001000,
      ST_SORT_LAST = 9'b000010000,
      ST_SORT_WJ   = 9'b000100000,
      ST_SORT_WB   = 9'b001000000,
      ST_OUT_RD    = 9'b010000000,
      ST_OUT_LOAD  = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] i_ff, i_in;

   always_comb begin
      state_in    = state_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.rd_tag  = TAG_NONE;
      cmd.rd_addr = i_ff;
      cmd.j_addr  = j_ff;
      case (state_ff)
         ST_COUNT: begin
            req_ready    = 1'b1;
            cmd.count_rd = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last count write lands this cycle
            j_in     = '0;
            state_in = ST_SORT_LOAD;
         end
         ST_SORT_LOAD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = j_ff;
            cmd.rd_tag  = TAG_FIRST;
            i_in        = j_ff + IDX_W'(1);
            state_in    = ST_SORT_SCAN;
         end
         ST_SORT_SCAN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = TAG_CMP;
            if (i_ff == LAST_IDX) begin
               state_in = ST_SORT_LAST;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_SORT_LAST: begin
            state_in = ST_SORT_WJ;
         end
         ST_SORT_WJ: begin
            cmd.wr_j = 1'b1;
            state_in = ST_SORT_WB;
         end
         ST_SORT_WB: begin
            cmd.wr_b = 1'b1;
            if (j_ff == LAST_SORT_IDX) begin
               i_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_SORT_LOAD;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (i_ff == LAST_IDX) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_COUNT;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_COUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
         j_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         i_ff     <= i_in;
      end
   end

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (state_ff == ST_DRAIN))
      else $error("last transfer did not start the drain");

   a_clear_on_final: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (cmd.out_load && i_ff == LAST_IDX))
      else $error("counters cleared before the final result");

   a_no_mem_ops_while_counting: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.wr_j || cmd.wr_b) |-> !req_ready)
      else $error("sort or readout access while taking input");

endmodule

`default_nettype wire

/* rtl/core/sfr_dpath.sv */
// sfr_dpath: class table memory, count read-modify-write, sort scan and output register
// depends on sfr_pkg; driven by commands from sfr_ctrl
`default_nettype none

module sfr_dpath
   import sfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   entry_type entry_mem [NUM_CLASSES];

   logic [NUM_CLASSES-1:0] vld_ff, vld_in;
   entry_type              rd_entry_ff;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_addr_ff, rd_addr_in;
   tag_type                rd_tag_ff, rd_tag_in;

   logic                   cls_vld_ff, cls_vld_in;
   logic [IDX_W-1:0]       cls_ff, cls_in;
   logic                   hit_ff, hit_in;
   logic [COUNT_WIDTH-1:0] wdata_ff, wdata_in;

   entry_type              best_ff, best_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   entry_type              jent_ff, jent_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   cls_type                cur_cls;
   logic                   cnt_rd;
   logic                   rd_go;
   logic [IDX_W-1:0]       rd_addr;
   entry_type              eff;
   logic [COUNT_WIDTH-1:0] base_cnt;
   logic [COUNT_WIDTH-1:0] inc_cnt;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   // read port: count lookup or sequencer address
   always_comb begin
      cur_cls = class_of(req_data.data_byte);
      cnt_rd  = cmd.count_rd && cur_cls.hit;
      rd_go   = cnt_rd || cmd.rd_en;
      rd_addr = cnt_rd ? cur_cls.idx : cmd.rd_addr;
   end

   // slots never written since the last clear read as their reset value
   always_comb begin
      eff.sym  = rd_vld_ff ? rd_entry_ff.sym : reset_symbol(rd_addr_ff);
      eff.cnt  = rd_vld_ff ? rd_entry_ff.cnt : '0;
      base_cnt = hit_ff ? wdata_ff : eff.cnt;
      inc_cnt  = sat_inc(base_cnt);
   end

   // write port: count update or one half of a swap
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = cls_ff;
      wr_data.sym = reset_symbol(cls_ff);
      wr_data.cnt = inc_cnt;
      if (cls_vld_ff) begin
         wr_en = 1'b1;
      end else if (cmd.wr_j) begin
         wr_en   = 1'b1;
         wr_addr = cmd.j_addr;
         wr_data = best_ff;
      end else if (cmd.wr_b) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = jent_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_go) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.clear) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      rd_vld_in  = rd_go ? vld_ff[rd_addr] : rd_vld_ff;
      rd_addr_in = rd_go ? rd_addr : rd_addr_ff;
      rd_tag_in  = cmd.rd_tag;
   end

   // count pipeline with bypass for back-to-back hits on one class
   always_comb begin
      cls_vld_in = cnt_rd;
      cls_in     = cnt_rd ? cur_cls.idx : cls_ff;
      hit_in     = cnt_rd && cls_vld_ff && (cur_cls.idx == cls_ff);
      wdata_in   = cls_vld_ff ? inc_cnt : wdata_ff;
   end

   // selection scan: first strictly greater count wins
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      jent_in     = jent_ff;
      case (rd_tag_ff)
         TAG_FIRST: begin
            best_in     = eff;
            best_idx_in = rd_addr_ff;
            jent_in     = eff;
         end
         TAG_CMP: begin
            if (eff.cnt > best_ff.cnt) begin
               best_in     = eff;
               best_idx_in = rd_addr_ff;
            end
         end
         default: begin
            best_in = best_ff;
         end
      endcase
   end

   always_comb begin
      sts.out_free = !rsp_valid_ff || rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_data_in.symbol_code  = eff.sym;
         rsp_data_in.symbol_count = sat_out(eff.cnt);
         rsp_data_in.rank_last    = (rd_addr_ff == LAST_IDX);
         rsp_valid_in             = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rd_tag_ff    <= TAG_NONE;
         cls_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rd_tag_ff    <= rd_tag_in;
         cls_vld_ff   <= cls_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff   <= rd_vld_in;
      rd_addr_ff  <= rd_addr_in;
      cls_ff      <= cls_in;
      wdata_ff    <= wdata_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      jent_ff     <= jent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_write_collision: assert property (@(posedge clock) disable iff (reset)
      !(cls_vld_ff && (cmd.wr_j || cmd.wr_b)))
      else $error("count write collides with a swap write");

   a_scan_after_best: assert property (@(posedge clock) disable iff (reset)
      (rd_tag_ff == TAG_CMP) |-> (rd_addr_ff > best_idx_ff))
      else $error("scan compared a slot at or before the current best");

   a_count_no_seq_read: assert property (@(posedge clock) disable iff (reset)
      cls_vld_ff |-> !cmd.rd_en)
      else $error("sequencer read during count update");

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for symbol_frequency_rank_core, byte stream in, ranked symbols out
// depends on sfr_pkg and symbol_frequency_rank_core; holds its own histogram and ranking model
`timescale 1ns / 1ps

module tb;
   import sfr_pkg::*;

   localparam int SORT_SETTLE  = 700;       // drain + sort + first result, with margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 370;
   localparam int LONG_RUN     = 40;        // bytes of one class, well ahead of the rest
   localparam int REPORT_MAX   = 10;
   localparam int HOLD_CYCLES  = 2000;
   localparam int HOLD_TEXT    = 6;         // long receiver hold-off during this text's output

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   symbol_frequency_rank_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // bytes waiting to be driven, and ranked results still owed by the block
   req_type text_queue[$];
   rsp_type ranked_expect[$];

   // histogram model: count and symbol per slot, in the order the sort leaves them
   logic [COUNT_WIDTH-1:0] tally [NUM_CLASSES];
   logic [7:0]             tally_sym [NUM_CLASSES];

   int mismatch_count = 0;
   int texts_ranked   = 0;
   int hold_left      = 0;
   bit hold_used      = 1'b0;
   int burst_left     = 0;
   int gap_left       = 0;
   int ready_mode     = 0;
   int mode_left      = 0;
   int cycle_count    = 0;

   // slot of a text byte, -1 when the byte is not counted
   function automatic int symbol_slot(input logic [7:0] b);
      if (b >= CHAR_LC_A && b <= CHAR_LC_Z) return int'(b - CHAR_LC_A);
      if (b >= CHAR_UC_A && b <= CHAR_UC_Z) return int'(b - CHAR_UC_A);
      if (b == CHAR_COMMA)  return int'(CLS_COMMA);
      if (b == CHAR_PERIOD) return int'(CLS_PERIOD);
      if (b == CHAR_EXCL)   return int'(CLS_EXCL);
      if (b == CHAR_SPACE)  return int'(CLS_SPACE);
      return -1;
   endfunction

   // symbol held by a slot when the table is empty
   function automatic logic [7:0] home_symbol(input int k);
      if (k == int'(CLS_COMMA))  return CHAR_COMMA;
      if (k == int'(CLS_PERIOD)) return CHAR_PERIOD;
      if (k == int'(CLS_EXCL))   return CHAR_EXCL;
      if (k == int'(CLS_SPACE))  return CHAR_SPACE;
      return CHAR_LC_A + 8'(k);
   endfunction

   task automatic clear_tally();
      int k;
      for (k = 0; k < NUM_CLASSES; k++) begin
         tally[k]     = '0;
         tally_sym[k] = home_symbol(k);
      end
   endtask

   // count one accepted byte; a byte marked last ranks the table and queues 30 results
   task automatic count_transfer(input req_type r);
      int                     k, i, j, best;
      logic [7:0]             s;
      logic [COUNT_WIDTH-1:0] c;
      rsp_type                e;
      k = symbol_slot(r.data_byte);
      if (k >= 0 && tally[k] != '1) begin
         tally[k] = tally[k] + 1'b1;   // saturating counter
      end
      if (r.last_byte) begin
         // descending selection sort, first strictly greater entry wins
         for (j = 0; j < NUM_CLASSES - 1; j++) begin
            best = j;
            for (i = j + 1; i < NUM_CLASSES; i++) begin
               if (tally[i] > tally[best]) best = i;
            end
            if (best != j) begin
               s               = tally_sym[j];
               c               = tally[j];
               tally_sym[j]    = tally_sym[best];
               tally[j]        = tally[best];
               tally_sym[best] = s;
               tally[best]     = c;
            end
         end
         for (k = 0; k < NUM_CLASSES; k++) begin
            e.symbol_code  = tally_sym[k];
            // clip to the output width when the counter is wider
            e.symbol_count = ((tally[k] >> OUT_CNT_W) != 0) ? '1 : OUT_CNT_W'(tally[k]);
            e.rank_last    = (k == NUM_CLASSES - 1);
            ranked_expect.insert(ranked_expect.size(), e);
         end
         clear_tally();
      end
   endtask

   task automatic push_item(input logic [7:0] b, input logic fin);
      req_type r;
      r.data_byte = b;
      r.last_byte = fin;
      text_queue.insert(text_queue.size(), r);
   endtask

   // random text character: crowded letters for ties, all classes, and some noise
   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return CHAR_LC_A + 8'($urandom_range(0, 4));
      if (r < 45) return CHAR_LC_A + 8'($urandom_range(0, 25));
      if (r < 65) return CHAR_UC_A + 8'($urandom_range(0, 25));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return CHAR_COMMA;
            1: return CHAR_PERIOD;
            2: return CHAR_EXCL;
            default: return CHAR_SPACE;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_text(input int len);
      int k;
      for (k = 0; k < len; k++) begin
         push_item(pick_char(), k == len - 1);
      end
   endtask

   // driver: bursts of transfers with random gaps, valid held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (text_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= text_queue.pop_front();
            if (burst_left <= 1) begin
               // occasional long bursts give stretches with no idling
               burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering bytes
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_used && rsp_valid && texts_ranked == HOLD_TEXT) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end
   end

   // receiver: stall pattern switches among modes over windows of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_mode <= 0;
         mode_left  <= 0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: rsp_ready <= (hold_left == 0);
            1: rsp_ready <= (hold_left == 0) && ($urandom_range(0, 1) == 0);
            2: rsp_ready <= (hold_left == 0) && ($urandom_range(0, 7) != 0);
            default: rsp_ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: input transfers feed the model, result transfers are checked in order
   always @(posedge clock) begin : watch
      rsp_type e;
      if (reset) begin
         clear_tally();
      end else begin
         if (req_valid && req_ready) begin
            count_transfer(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (ranked_expect.size() == 0) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("unexpected result: code %h count %0d last %0b",
                           rsp_data.symbol_code, rsp_data.symbol_count, rsp_data.rank_last);
               end
               mismatch_count = mismatch_count + 1;
            end else begin
               e = ranked_expect.pop_front();
               if (rsp_data.symbol_code !== e.symbol_code ||
                   rsp_data.symbol_count !== e.symbol_count ||
                   rsp_data.rank_last !== e.rank_last) begin
                  if (mismatch_count < REPORT_MAX) begin
                     $display("expected code %h count %0d last %0b, got %h %0d %0b",
                              e.symbol_code, e.symbol_count, e.rank_last,
                              rsp_data.symbol_code, rsp_data.symbol_count, rsp_data.rank_last);
                  end
                  mismatch_count = mismatch_count + 1;
               end
            end
            if (rsp_data.rank_last) texts_ranked <= texts_ranked + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("symbol_frequency_rank_core: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int n, len;

      // ignored byte marked last on an empty table: all counts zero
      push_item(8'h00, 1'b1);

      // case folding, class borders, punctuation, noise and high bytes
      push_item(CHAR_UC_A, 1'b0);
      push_item(CHAR_LC_Z, 1'b0);
      push_item(CHAR_UC_Z, 1'b0);
      push_item(CHAR_LC_A, 1'b0);
      push_item(8'hff, 1'b0);
      push_item(8'h40, 1'b0);        // just below 'A'
      push_item(8'h5b, 1'b0);        // just above 'Z'
      push_item(8'h60, 1'b0);        // just below 'a'
      push_item(8'h7b, 1'b0);        // just above 'z'
      push_item(CHAR_COMMA, 1'b0);
      push_item(CHAR_PERIOD, 1'b0);
      push_item(CHAR_EXCL, 1'b0);
      push_item(CHAR_SPACE, 1'b0);
      push_item(8'h80, 1'b0);
      push_item(8'h7f, 1'b0);
      push_item(8'h2d, 1'b0);        // hyphen, not counted
      push_item(CHAR_LC_A + 8'd12, 1'b1);

      // counted byte marked last on its own
      push_item(CHAR_SPACE, 1'b1);

      // ties between letters and punctuation
      push_item(CHAR_LC_A + 8'd1, 1'b0);
      push_item(CHAR_LC_A, 1'b0);
      push_item(CHAR_UC_A + 8'd1, 1'b0);
      push_item(CHAR_SPACE, 1'b0);
      push_item(CHAR_UC_A, 1'b0);
      push_item(CHAR_EXCL, 1'b1);

      // one class far ahead in mixed case, a few others beside it
      for (n = 0; n < LONG_RUN; n++) begin
         push_item(n[0] ? CHAR_UC_A + 8'd4 : CHAR_LC_A + 8'd4, 1'b0);
      end
      push_item(CHAR_COMMA, 1'b0);
      push_item(CHAR_LC_A + 8'd16, 1'b0);
      push_item(CHAR_LC_A + 8'd23, 1'b1);

      // random texts, mostly short, some long
      n = 0;
      while (n < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 25);
         queue_text(len);
         n = n + len;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // everything driven and every ranked result back
      while (text_queue.size() > 0 || req_valid || ranked_expect.size() > 0) begin
         @(negedge clock);
      end
      // room for any stray result
      repeat (SORT_SETTLE) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("symbol_frequency_rank_core: match");
      end else begin
         $display("symbol_frequency_rank_core: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/sfr_pkg.sv
rtl/core/sfr_ctrl.sv
rtl/core/sfr_dpath.sv
rtl/core/symbol_frequency_rank_core.sv
tb/tb.sv
